/* rtl/core/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    ST_OPEN     = 2'd0,
    ST_CLOSED   = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSL   = 8'h5c;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_B     = 8'h62;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_R     = 8'h72;
  localparam logic [7:0] CHR_N     = 8'h6e;
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // one decoded input item: up to three output bytes
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic            has_byte;
    logic [1:0]      last_idx;
    status_e         status;
  } job_t;

endpackage

/* rtl/core/jsu_front.sv */
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output job_t       job_o
);

  logic        esc_q, esc_d;
  logic [2:0]  hex_q, hex_d;
  logic [15:0] cp_q, cp_d;

  logic [15:0]     digit;
  logic [15:0]     cp_shift;
  logic [2:0][7:0] bytes;
  logic [1:0]      n;
  logic            closed;
  logic            uerr;
  status_e         status;

  always_comb begin
    esc_d  = esc_q;
    hex_d  = hex_q;
    cp_d   = cp_q;
    bytes  = '0;
    n      = 2'd0;
    closed = 1'b0;
    uerr   = 1'b0;

    if (text_byte_i <= CHR_NINE) begin
      digit = {8'h00, text_byte_i} - 16'h0030;
    end else begin
      digit = {13'd0, text_byte_i[2:0]} + 16'd9;
    end
    cp_shift = {cp_q[11:0], 4'h0} + digit;

    if (hex_q != 3'd0) begin
      cp_d = cp_shift;
      if (hex_q >= 3'd4) begin
        hex_d = 3'd0;
        if (end_of_text_i) begin
          uerr = 1'b1;
        end else if (cp_shift == 16'h0000) begin
          n = 2'd0;
        end else if (cp_shift < 16'h0080) begin
          bytes[0] = cp_shift[7:0];
          n = 2'd1;
        end else if (cp_shift < 16'h0800) begin
          bytes[0] = 8'hc0 | {3'b000, cp_shift[10:6]};
          bytes[1] = 8'h80 | {2'b00, cp_shift[5:0]};
          n = 2'd2;
        end else begin
          bytes[0] = 8'he0 | {4'h0, cp_shift[15:12]};
          bytes[1] = 8'h80 | {2'b00, cp_shift[11:6]};
          bytes[2] = 8'h80 | {2'b00, cp_shift[5:0]};
          n = 2'd3;
        end
      end else begin
        hex_d = hex_q + 3'd1;
        uerr  = end_of_text_i;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      case (text_byte_i)
        CHR_T: begin bytes[0] = 8'h09; n = 2'd1; end
        CHR_B: begin bytes[0] = 8'h08; n = 2'd1; end
        CHR_F: begin bytes[0] = 8'h0c; n = 2'd1; end
        CHR_R: begin bytes[0] = 8'h0d; n = 2'd1; end
        CHR_N: begin bytes[0] = 8'h0a; n = 2'd1; end
        CHR_U: begin
          hex_d = 3'd1;
          cp_d  = 16'h0000;
          uerr  = end_of_text_i;
        end
        default: begin bytes[0] = text_byte_i; n = 2'd1; end
      endcase
    end else if (text_byte_i == CHR_BSL) begin
      esc_d = 1'b1;
    end else if (text_byte_i == CHR_QUOTE) begin
      closed = 1'b1;
    end else begin
      bytes[0] = text_byte_i;
      n = 2'd1;
    end

    if (uerr) begin
      status = ST_TRUNC;
    end else if (closed) begin
      status = ST_CLOSED;
    end else if (end_of_text_i) begin
      status = ST_UNCLOSED;
    end else begin
      status = ST_OPEN;
    end

    if (status != ST_OPEN) begin
      esc_d = 1'b0;
      hex_d = 3'd0;
      cp_d  = 16'h0000;
    end

    job_o.bytes    = bytes;
    job_o.has_byte = (n != 2'd0);
    job_o.last_idx = (n == 2'd0) ? 2'd0 : n - 2'd1;
    job_o.status   = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      hex_q <= 3'd0;
      cp_q  <= 16'h0000;
    end else if (accept_i) begin
      esc_q <= esc_d;
      hex_q <= hex_d;
      cp_q  <= cp_d;
    end
  end

endmodule

/* rtl/core/jsu_fifo.sv */
`timescale 1ns / 1ps

module jsu_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntMax);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + PtrW'(1);
      end
    end
  end

endmodule

/* rtl/core/jsu_back.sv */
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output status_e    status_o,
  output logic       last_o
);

  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  job_t       job_q;
  logic       last;

  assign last      = (idx_q == job_q.last_idx);
  assign job_pop_o = job_valid_i && (!busy_q || (ready_i && last));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (job_pop_o) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (busy_q && ready_i) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  assign valid_o    = busy_q;
  assign out_byte_o = job_q.bytes[idx_q];
  assign has_byte_o = job_q.has_byte;
  assign status_o   = job_q.status;
  assign last_o     = last;

endmodule

/* rtl/core/json_string_unescape_utf8.sv */
// JSON string body unescaper: one byte of the string body per input item
// (after the opening quote), decoded to UTF-8 result items. Each input item
// gives one to three results; an item that decodes no byte gives one result
// with has_byte low. The status rides on every result, and tlast marks the
// final result of each input item. Input is taken one item per cycle while
// the queue is not full, and results leave one per cycle while m_axis_tready
// is high, so the rate is set by the output side. A queue of FifoDepth
// decoded items sits between the decoder and the output stage; input stalls
// only while it is full. An input item is registered in the queue and then
// in the output stage before its first result appears.
`timescale 1ns / 1ps

module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] text_byte
  input  logic       s_axis_tlast,  // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [2:0] m_axis_tuser,  // [0] has_byte, [2:1] status
  output logic       m_axis_tlast   // last_of_run
);

  logic    accept;
  logic    fifo_full;
  logic    fifo_valid;
  logic    fifo_pop;
  job_t    job_new;
  job_t    job_head;
  logic    has_byte;
  status_e status;

  assign s_axis_tready = !fifo_full;
  assign accept        = s_axis_tvalid && !fifo_full;

  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (s_axis_tdata),
    .end_of_text_i(s_axis_tlast),
    .job_o        (job_new)
  );

  jsu_fifo #(
    .Width($bits(job_t)),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(job_new),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .valid_o(fifo_valid),
    .rdata_o(job_head)
  );

  jsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(fifo_valid),
    .job_i      (job_head),
    .job_pop_o  (fifo_pop),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .has_byte_o (has_byte),
    .status_o   (status),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tuser = {status, has_byte};

endmodule

/* rtl/core/jsu_checker.sv */
`timescale 1ns / 1ps

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  // empty result is a single zero item
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00 && m_axis_tlast))
    else $error("empty result malformed");

  // results before the last of a run carry bytes
  a_mid_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser[0])
    else $error("non-final result without byte");

  // a run continues back to back with the same status
  a_run_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser[0]
       && m_axis_tuser[2:1] == $past(m_axis_tuser[2:1])))
    else $error("run broken or status changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
